// ===== rtl/core/svrd_pkg.sv =====
// Shared types and constants for the space-vector ramp duty generator.
// Used by every module under rtl/core; depends on nothing else.
package svrd_pkg;

	// Register indexes on the configuration port.
	localparam logic [2:0] REG_FS_MAX       = 3'd0;
	localparam logic [2:0] REG_VEL_STEP     = 3'd1;
	localparam logic [2:0] REG_TICK_TIME    = 3'd2;
	localparam logic [2:0] REG_HALF_ACCEL   = 3'd3;
	localparam logic [2:0] REG_PHASE_GAIN   = 3'd4;
	localparam logic [2:0] REG_PERIOD_COUNT = 3'd5;

	// pi/3 in Q2.30, the span of one sector.
	localparam longint unsigned PI3_Q30 = 64'd1124419809;
	localparam logic [15:0] MOD_ONE = 16'd32768;

	localparam logic signed [44:0] W41_MAX = 45'sd1099511627775;
	localparam logic signed [44:0] W41_MIN = -45'sd1099511627776;

	typedef struct packed {
		logic signed [40:0] set_freq;
		logic [15:0]        mod_index;
	} item_t;

	typedef struct packed {
		logic [39:0] fs_max;
		logic [39:0] vel_step;
		logic [31:0] tick_time;
		logic [39:0] half_accel_term;
		logic [31:0] phase_gain;
		logic [15:0] period_count;
	} cfg_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_RAMP,
		ST_VMUL,
		ST_FREQ,
		ST_PMUL,
		ST_PHASE,
		ST_ROM,
		ST_TERM,
		ST_OUT
	} state_t;

	function automatic logic signed [40:0] sat41(input logic signed [44:0] v);
		logic signed [44:0] r;
		r = v;
		if (v > W41_MAX) r = W41_MAX;
		if (v < W41_MIN) r = W41_MIN;
		return r[40:0];
	endfunction

endpackage

// ===== rtl/core/svpwm_ramp_duty_generator.sv =====
// Space-vector PWM duty generator with frequency ramp, one beat per tick.
// The sequencer waits in its output state while an earlier result waits on
// m_tready. One tick is in work at a time: the step sequencer in svrd_back
// takes a new beat only once the last result is loaded, and a target equal to
// the kept frequency skips the velocity multiply and frequency update steps.
// Reset clears the queue, the ramp state, the phase and the registers to their defaults.
module svpwm_ramp_duty_generator #(
	parameter int PHASE_BITS   = 32,
	parameter int SINE_ENTRIES = 1024,
	parameter int COUNT_BITS   = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,   // set_freq[40:0], mod_index[56:41], zeros
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [55:0] m_tdata,   // compare_u, compare_v, compare_w, sector_out, zeros
	input  logic        cfg_we,
	input  logic [2:0]  cfg_addr,
	input  logic [39:0] cfg_wdata
);
	import svrd_pkg::*;

	cfg_t        cfg_q;
	item_t       in_item;
	item_t       q_item;
	logic        q_valid;
	logic        q_pop;
	logic [15:0] compare_u, compare_v, compare_w;
	logic [2:0]  sector_out;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.fs_max          <= 40'd1677721600;
			cfg_q.vel_step        <= 40'd33554;
			cfg_q.tick_time       <= 32'd858993;
			cfg_q.half_accel_term <= 40'd3;
			cfg_q.phase_gain      <= 32'd214748;
			cfg_q.period_count    <= 16'd8499;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				REG_FS_MAX:       cfg_q.fs_max          <= cfg_wdata;
				REG_VEL_STEP:     cfg_q.vel_step        <= cfg_wdata;
				REG_TICK_TIME:    cfg_q.tick_time       <= cfg_wdata[31:0];
				REG_HALF_ACCEL:   cfg_q.half_accel_term <= cfg_wdata;
				REG_PHASE_GAIN:   cfg_q.phase_gain      <= cfg_wdata[31:0];
				REG_PERIOD_COUNT: cfg_q.period_count    <= cfg_wdata[15:0];
				default: ;
			endcase
		end
	end

	assign in_item.set_freq  = $signed(s_tdata[40:0]);
	assign in_item.mod_index = s_tdata[56:41];

	svrd_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.in_item  (in_item),
		.fs_max   (cfg_q.fs_max),
		.q_valid  (q_valid),
		.q_pop    (q_pop),
		.q_item   (q_item)
	);

	svrd_back #(
		.PHASE_BITS   (PHASE_BITS),
		.SINE_ENTRIES (SINE_ENTRIES),
		.COUNT_BITS   (COUNT_BITS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.q_valid    (q_valid),
		.q_pop      (q_pop),
		.q_item     (q_item),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.compare_u  (compare_u),
		.compare_v  (compare_v),
		.compare_w  (compare_w),
		.sector_out (sector_out)
	);

	assign m_tdata = {5'b0, sector_out, compare_w, compare_v, compare_u};

endmodule

// ===== rtl/core/svrd_front.sv =====
// Input side: clamps target frequency and modulation index of each beat
// and holds the items in a two-entry queue. Depends on svrd_pkg.
module svrd_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  svrd_pkg::item_t     in_item,
	input  logic [39:0]         fs_max,
	output logic                q_valid,
	input  logic                q_pop,
	output svrd_pkg::item_t     q_item
);
	import svrd_pkg::*;

	item_t              mem_q [2];
	logic               wr_ptr_q;
	logic               rd_ptr_q;
	logic [1:0]         count_q;
	logic signed [40:0] lim;
	item_t              clamped;
	logic               push;
	logic               pop;

	always_comb begin
		lim = $signed({1'b0, fs_max});
		clamped = in_item;
		if (in_item.set_freq > lim) clamped.set_freq = lim;
		if (in_item.set_freq < -lim) clamped.set_freq = -lim;
		if (in_item.mod_index > MOD_ONE) clamped.mod_index = MOD_ONE;
	end

	assign s_tready = (count_q != 2'd2);
	assign push     = s_tvalid && s_tready;
	assign q_valid  = (count_q != 2'd0);
	assign pop      = q_pop && q_valid;
	assign q_item   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= clamped;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (pop) rd_ptr_q <= ~rd_ptr_q;
			count_q <= count_q + 2'(push) - 2'(pop);
		end
	end

endmodule

// ===== rtl/core/svrd_back.sv =====
// Sequencer that ramps the frequency, advances phase, looks up the sine
// table and forms the three compare counts. Depends on svrd_pkg.
module svrd_back #(
	parameter int PHASE_BITS   = 32,
	parameter int SINE_ENTRIES = 1024,
	parameter int COUNT_BITS   = 16
) (
	input  logic            clk,
	input  logic            arst_n,
	input  svrd_pkg::cfg_t  cfg,
	input  logic            q_valid,
	output logic            q_pop,
	input  svrd_pkg::item_t q_item,
	output logic            m_tvalid,
	input  logic            m_tready,
	output logic [15:0]     compare_u,
	output logic [15:0]     compare_v,
	output logic [15:0]     compare_w,
	output logic [2:0]      sector_out
);
	import svrd_pkg::*;

	localparam int LOG_E = $clog2(SINE_ENTRIES);
	localparam int PW    = 24 + PHASE_BITS;

	typedef logic [15:0] tab_t [0:SINE_ENTRIES];

	// Sine over one sector in Q1.15, a Q2.30 Taylor series to x^13.
	function automatic tab_t build_tab();
		tab_t               t;
		longint unsigned    x;
		longint unsigned    x2;
		longint unsigned    term;
		longint             sum;
		for (int k = 0; k <= SINE_ENTRIES; k++) begin
			x    = (64'(k) * PI3_Q30) / SINE_ENTRIES;
			x2   = (x * x) >> 30;
			term = x;
			sum  = longint'(x);
			for (int n = 1; n <= 6; n++) begin
				term = (term * x2) >> 30;
				case (n)
					1:       term = term / 64'd6;
					2:       term = term / 64'd20;
					3:       term = term / 64'd42;
					4:       term = term / 64'd72;
					5:       term = term / 64'd110;
					default: term = term / 64'd156;
				endcase
				if (n % 2 == 1) sum = sum - longint'(term);
				else sum = sum + longint'(term);
			end
			if (sum < 0) sum = 0;
			t[k] = 16'((64'(sum) + 64'd16384) >> 15);
		end
		return t;
	endfunction

	localparam tab_t SINE_TAB = build_tab();

	state_t state_q, state_d;

	item_t                   item_q;
	logic signed [40:0]      freq_q;
	logic signed [40:0]      vel_q;
	logic [PHASE_BITS-1:0]   phase_q;
	logic                    up_q;
	logic [52:0]             vhi_q;
	logic [51:0]             vlo_q;
	logic signed [53:0]      phi_q;
	logic [51:0]             plo_q;
	logic [COUNT_BITS+15:0]  mp_q;
	logic [2:0]              sector_q;
	logic [15:0]             tab_a_q;
	logic [15:0]             tab_b_q;
	logic [17:0]             ta_q;
	logic [17:0]             tb_q;
	logic                    m_tvalid_q;
	logic [15:0]             cu_q, cv_q, cw_q;
	logic [2:0]              sec_out_q;

	logic                    load_out;
	logic [COUNT_BITS-1:0]   p;
	logic signed [40:0]      tgt;
	logic signed [44:0]      vel_sum;
	logic [40:0]             vmag;
	logic [73:0]             vfull;
	logic signed [44:0]      rs;
	logic signed [44:0]      nf;
	logic                    snap;
	logic [PW-1:0]           psum;
	logic [PHASE_BITS+2:0]   six;
	logic [LOG_E-1:0]        idx;
	logic [18:0]             s, h, cu, cv, cw, p19;

	assign p   = cfg.period_count[COUNT_BITS-1:0];
	assign tgt = item_q.set_freq;

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:  if (q_valid) state_d = ST_RAMP;
			ST_RAMP:  state_d = (freq_q == tgt) ? ST_PMUL : ST_VMUL;
			ST_VMUL:  state_d = ST_FREQ;
			ST_FREQ:  state_d = ST_PMUL;
			ST_PMUL:  state_d = ST_PHASE;
			ST_PHASE: state_d = ST_ROM;
			ST_ROM:   state_d = ST_TERM;
			ST_TERM:  state_d = ST_OUT;
			ST_OUT:   if (!m_tvalid_q || m_tready) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	// Sequencer outputs.
	always_comb begin
		q_pop    = (state_q == ST_IDLE) && q_valid;
		load_out = (state_q == ST_OUT) && (!m_tvalid_q || m_tready);
	end

	always_comb begin
		vel_sum = up_q ? 45'(vel_q) : 45'(vel_q);
		if (freq_q < tgt) vel_sum = 45'(vel_q) + $signed({5'b0, cfg.vel_step});
		else vel_sum = 45'(vel_q) - $signed({5'b0, cfg.vel_step});
		vmag  = vel_q[40] ? 41'(-vel_q) : vel_q;
		vfull = {1'b0, vhi_q, 20'b0} + 74'(vlo_q);
		rs    = vel_q[40] ? -$signed({3'b0, vfull[73:32]}) : $signed({3'b0, vfull[73:32]});
		if (up_q) nf = 45'(freq_q) + rs + $signed({5'b0, cfg.half_accel_term});
		else nf = 45'(freq_q) + rs - $signed({5'b0, cfg.half_accel_term});
		snap  = up_q ? (nf > 45'(tgt)) : (nf < 45'(tgt));
		psum  = (PW'(phi_q) << 20) + PW'(plo_q);
		six   = {phase_q, 2'b0} + {1'b0, phase_q, 1'b0};
		idx   = six[PHASE_BITS-1 -: LOG_E];
	end

	always_comb begin
		p19 = 19'(p);
		s   = 19'(ta_q) + 19'(tb_q);
		h   = (s >= p19) ? 19'd0 : ((p19 - s) >> 1);
		case (sector_q)
			3'd0: begin cu = s + h;        cv = 19'(tb_q) + h; cw = h;              end
			3'd1: begin cu = 19'(ta_q) + h; cv = s + h;        cw = h;              end
			3'd2: begin cu = h;            cv = s + h;        cw = 19'(tb_q) + h;  end
			3'd3: begin cu = h;            cv = 19'(ta_q) + h; cw = s + h;         end
			3'd4: begin cu = 19'(tb_q) + h; cv = h;            cw = s + h;         end
			default: begin cu = s + h;     cv = h;            cw = 19'(ta_q) + h;  end
		endcase
		if (cu > p19) cu = p19;
		if (cv > p19) cv = p19;
		if (cw > p19) cw = p19;
		if (item_q.mod_index == 16'd0 || p == '0) begin
			cu = '0;
			cv = '0;
			cw = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			freq_q     <= '0;
			vel_q      <= '0;
			phase_q    <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_RAMP) begin
				if (freq_q == tgt) begin
					vel_q  <= '0;
					freq_q <= tgt;
				end else begin
					vel_q <= sat41(vel_sum);
				end
			end
			if (state_q == ST_FREQ) begin
				freq_q <= snap ? tgt : sat41(nf);
				if (snap) vel_q <= '0;
			end
			if (state_q == ST_PHASE) phase_q <= phase_q + psum[PW-1:24];
			if (load_out) m_tvalid_q <= 1'b1;
			else if (m_tready) m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) item_q <= q_item;
		if (state_q == ST_RAMP) up_q <= (freq_q < tgt);
		if (state_q == ST_VMUL) begin
			vhi_q <= vmag[40:20] * cfg.tick_time;
			vlo_q <= vmag[19:0] * cfg.tick_time;
		end
		if (state_q == ST_PMUL) begin
			phi_q <= $signed(freq_q[40:20]) * $signed({1'b0, cfg.phase_gain});
			plo_q <= freq_q[19:0] * cfg.phase_gain;
			mp_q  <= item_q.mod_index * p;
		end
		if (state_q == ST_ROM) begin
			sector_q <= six[PHASE_BITS+2:PHASE_BITS];
			tab_a_q  <= SINE_TAB[(LOG_E+1)'(SINE_ENTRIES) - {1'b0, idx}];
			tab_b_q  <= SINE_TAB[{1'b0, idx}];
		end
		if (state_q == ST_TERM) begin
			ta_q <= 18'((48'(mp_q) * 48'(tab_a_q)) >> 30);
			tb_q <= 18'((48'(mp_q) * 48'(tab_b_q)) >> 30);
		end
		if (load_out) begin
			cu_q      <= cu[15:0];
			cv_q      <= cv[15:0];
			cw_q      <= cw[15:0];
			sec_out_q <= sector_q;
		end
	end

	assign m_tvalid   = m_tvalid_q;
	assign compare_u  = cu_q;
	assign compare_v  = cv_q;
	assign compare_w  = cw_q;
	assign sector_out = sec_out_q;

endmodule
